>>> hdl/igl_pkg.sv
// ----------------------------------------------------------------------------
// igl_pkg
// Shared constants for the inverse Gaussian log density pipeline.
// ----------------------------------------------------------------------------
package igl_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;

  // log2 unit: Q24 fraction, one squaring per stage after normalization
  localparam int LOG_FRAC   = 24;
  localparam int LOG_STEPS  = LOG_FRAC;
  localparam int LOG_W      = 5 + LOG_FRAC;
  localparam int LOG_LAT    = LOG_STEPS + 1;

  // divider: four product stages, one range check, one quotient bit per stage
  localparam int DIV_STEPS  = 32;
  localparam int DIV_LAT    = DIV_STEPS + 5;
  localparam int WIDE_W     = 128;

  localparam int BASE_LAT   = 3;
  localparam int BASE_DLY   = DIV_LAT - LOG_LAT - BASE_LAT;
  localparam int PIPE_N     = DIV_LAT + 2;

  localparam int T_W        = 34;
  localparam int RND_SHIFT  = 55 - FRAC_BITS;

  localparam logic signed [63:0] LN2_Q30         = 64'sd744261118;
  localparam logic signed [63:0] HALF_LN_2PI_Q32 = 64'sd3946810947;
  localparam logic signed [T_W-1:0] T_OFFSET     = T_W'(2 * FRAC_BITS) <<< LOG_FRAC;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE = 2'd1;

endpackage

>>> hdl/igl_log2.sv
// ----------------------------------------------------------------------------
// igl_log2
// Pipelined log2 in Q24: normalize, then one mantissa squaring per stage.
// ----------------------------------------------------------------------------
module igl_log2 (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [igl_pkg::DATA_W-1:0]        val_i,
  output logic [igl_pkg::LOG_W-1:0]         log_o
);
  import igl_pkg::*;

  logic [4:0]          e_q    [0:LOG_STEPS];
  logic [LOG_FRAC-1:0] frac_q [0:LOG_STEPS];
  logic [30:0]         m_q    [0:LOG_STEPS-1];

  logic [4:0]  e_d;
  logic [62:0] norm;

  always_comb begin
    e_d = '0;
    for (int b = 0; b < DATA_W; b++) begin
      if (val_i[b]) e_d = 5'(b);
    end
    norm = ({31'b0, val_i} << 30) >> e_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_q[0]    <= e_d;
      frac_q[0] <= '0;
      m_q[0]    <= norm[30:0];
    end
  end

  for (genvar j = 0; j < LOG_STEPS; j++) begin : g_sq
    logic [61:0] prod;
    logic [31:0] sq;
    assign prod = {31'b0, m_q[j]} * {31'b0, m_q[j]};
    assign sq   = prod[61:30];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        e_q[j+1]    <= e_q[j];
        frac_q[j+1] <= frac_q[j] | (sq[31] ? (LOG_FRAC'(1) << (LOG_STEPS-1-j)) : '0);
      end
    end

    if (j < LOG_STEPS - 1) begin : g_m
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          m_q[j+1] <= sq[31] ? sq[31:1] : sq[30:0];
        end
      end
    end
  end

  assign log_o = {e_q[LOG_STEPS], frac_q[LOG_STEPS]};

endmodule

>>> hdl/igl_div.sv
// ----------------------------------------------------------------------------
// igl_div
// Pipelined quotient floor(lam*(x-mu)^2*2^(F-1) / (mu^2*x)) with range flag.
// ----------------------------------------------------------------------------
module igl_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [igl_pkg::DATA_W-1:0] x_i,
  input  logic [igl_pkg::DATA_W-1:0] mu_i,
  input  logic [igl_pkg::DATA_W-1:0] lam_i,
  output logic [igl_pkg::DATA_W-1:0] quot_o,
  output logic                       sat_o
);
  import igl_pkg::*;

  // product stages
  logic [31:0]       d1_q, x1_q, lam1_q, lam2_q;
  logic [63:0]       mm1_q, dd2_q, denl2_q, denh2_q, numl3_q, numh3_q;
  logic [95:0]       den3_q;
  logic [WIDE_W-1:0] num4_q, den4_q;

  logic [95:0]       num_sum;
  assign num_sum = {32'b0, numl3_q} + {numh3_q, 32'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q    <= (x_i >= mu_i) ? (x_i - mu_i) : (mu_i - x_i);
      mm1_q   <= {32'b0, mu_i} * {32'b0, mu_i};
      x1_q    <= x_i;
      lam1_q  <= lam_i;
      dd2_q   <= {32'b0, d1_q} * {32'b0, d1_q};
      denl2_q <= {32'b0, mm1_q[31:0]} * {32'b0, x1_q};
      denh2_q <= {32'b0, mm1_q[63:32]} * {32'b0, x1_q};
      lam2_q  <= lam1_q;
      den3_q  <= {32'b0, denl2_q} + {denh2_q, 32'b0};
      numl3_q <= {32'b0, dd2_q[31:0]} * {32'b0, lam2_q};
      numh3_q <= {32'b0, dd2_q[63:32]} * {32'b0, lam2_q};
      num4_q  <= WIDE_W'(num_sum) << (FRAC_BITS - 1);
      den4_q  <= WIDE_W'(den3_q);
    end
  end

  // restoring division, one quotient bit per stage
  logic [WIDE_W-1:0] rem_q [0:DIV_STEPS-1];
  logic [WIDE_W-1:0] den_q [0:DIV_STEPS-1];
  logic [31:0]       q_q   [0:DIV_STEPS];
  logic              sat_q [0:DIV_STEPS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q[0] <= num4_q >= (den4_q << 32);
      rem_q[0] <= num4_q;
      den_q[0] <= den4_q;
      q_q[0]   <= '0;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [WIDE_W-1:0] sh;
    logic              ge;
    assign sh = den_q[j] << (DIV_STEPS - 1 - j);
    assign ge = rem_q[j] >= sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[j+1]   <= q_q[j] | (ge ? (32'd1 << (DIV_STEPS - 1 - j)) : 32'd0);
        sat_q[j+1] <= sat_q[j];
      end
    end

    if (j < DIV_STEPS - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= ge ? (rem_q[j] - sh) : rem_q[j];
          den_q[j+1] <= den_q[j];
        end
      end
    end
  end

  assign quot_o = q_q[DIV_STEPS];
  assign sat_o  = sat_q[DIV_STEPS];

endmodule

>>> hdl/inverse_gaussian_log_pdf.sv
// ----------------------------------------------------------------------------
// inverse_gaussian_log_pdf
// Streaming log density of the inverse Gaussian distribution, Q16.16 in/out.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i/data | write mean / shape
//  in      | in_valid_i in_ready_o sample_i           | sample x
//  out     | out_valid_o out_ready_i log_density_o,   | result
//          | out_of_support_o                         |
//
// One sample per cycle while the output is not stalled.
// Pipeline depth is set by the 32-stage quotient pipeline plus operand products.
// The whole pipeline advances when the output register is empty or taken;
// a stalled output holds every stage, so nothing is lost or repeated.
// Reset clears valid bits and loads mean and shape with 1.0.
// ----------------------------------------------------------------------------
module inverse_gaussian_log_pdf (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [igl_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [igl_pkg::DATA_W-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [igl_pkg::DATA_W-1:0]           sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [igl_pkg::DATA_W-1:0]    log_density_o,
  output logic                                 out_of_support_o
);
  import igl_pkg::*;

  logic [DATA_W-1:0] mean_q, shape_q;
  logic              en;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q  <= DATA_W'(1) << FRAC_BITS;
      shape_q <= DATA_W'(1) << FRAC_BITS;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MEAN:  mean_q  <= cfg_data_i;
        CFG_SHAPE: shape_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // valid and out-of-support flags ride alongside the data
  logic [PIPE_N-1:0] vld_q, zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_N-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q <= {zero_q[PIPE_N-2:0], (sample_i == '0)};
    end
  end

  // input stage: substitute one LSB for zero mean, shape and log operand; the divider gets the raw sample
  logic [DATA_W-1:0] x0_q, mu0_q, lam0_q, xl0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q   <= sample_i;
      xl0_q  <= (sample_i == '0) ? DATA_W'(1) : sample_i;
      mu0_q  <= (mean_q == '0) ? DATA_W'(1) : mean_q;
      lam0_q <= (shape_q == '0) ? DATA_W'(1) : shape_q;
    end
  end

  logic [LOG_W-1:0]  log_x, log_lam;
  logic [DATA_W-1:0] quot;
  logic              sat;

  igl_log2 u_log_x (
    .clk_i (clk_i),
    .en_i  (en),
    .val_i (xl0_q),
    .log_o (log_x)
  );

  igl_log2 u_log_lam (
    .clk_i (clk_i),
    .en_i  (en),
    .val_i (lam0_q),
    .log_o (log_lam)
  );

  igl_div u_div (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (x0_q),
    .mu_i   (mu0_q),
    .lam_i  (lam0_q),
    .quot_o (quot),
    .sat_o  (sat)
  );

  // base term: scale log2 sum by ln2, subtract half ln(2pi), round
  logic signed [T_W-1:0] t_q, lx_s, ll_s;
  logic signed [63:0]    v55_q, base_q;
  logic [63:0]           mag, rnd;

  assign lx_s = $signed({{(T_W-LOG_W){1'b0}}, log_x});
  assign ll_s = $signed({{(T_W-LOG_W){1'b0}}, log_lam});
  assign mag  = v55_q[63] ? (64'd0 - v55_q) : v55_q;
  assign rnd  = (mag + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q    <= ll_s - (lx_s <<< 1) - lx_s + T_OFFSET;
      v55_q  <= 64'(t_q) * LN2_Q30 - (HALF_LN_2PI_Q32 <<< 23);
      base_q <= v55_q[63] ? -$signed(rnd) : $signed(rnd);
    end
  end

  // hold the base term until the quotient catches up
  logic signed [63:0] bdly_q [0:BASE_DLY-1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      bdly_q[0] <= base_q;
      for (int i = 1; i < BASE_DLY; i++) bdly_q[i] <= bdly_q[i-1];
    end
  end

  logic signed [65:0]       diff;
  logic signed [DATA_W-1:0] res_d, res_q;
  logic                     oos_q;

  assign diff = 66'(bdly_q[BASE_DLY-1]) - $signed({34'b0, quot});

  always_comb begin
    priority if (zero_q[DIV_LAT] || sat) begin
      res_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (diff < -66'sd2147483648) begin
      res_d = {1'b1, {(DATA_W-1){1'b0}}};
    end else if (diff > 66'sd2147483647) begin
      res_d = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      res_d = diff[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      oos_q <= zero_q[DIV_LAT];
    end
  end

  assign out_valid_o      = vld_q[PIPE_N-1];
  assign log_density_o    = res_q;
  assign out_of_support_o = oos_q;

endmodule

>>> hdl/igl_checker.sv
// ----------------------------------------------------------------------------
// igl_checker
// Port-level checks on the log density block, bound to the top level.
// ----------------------------------------------------------------------------
module igl_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic signed [igl_pkg::DATA_W-1:0] log_density_o,
  input logic                             out_of_support_o
);
  import igl_pkg::*;

  a_oos_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_support_o |-> log_density_o == {1'b1, {(DATA_W-1){1'b0}}})
    else $error("out of support result is not the minimum");

  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_empty_takes_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(log_density_o)
      && $stable(out_of_support_o))
    else $error("stalled result changed");

endmodule

bind inverse_gaussian_log_pdf igl_checker u_igl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_o       (in_ready_o),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .log_density_o    (log_density_o),
  .out_of_support_o (out_of_support_o)
);
